### rtl/het_pkg.sv
// Shared types, codes and constants of the hysteresis edge tracking core.
package het_pkg;

   localparam int unsigned PIX_AW      = 16;
   localparam int unsigned STORE_DEPTH = 65536;
   localparam int unsigned CNT_W       = 17;
   localparam int unsigned DIM_W       = 9;
   localparam int unsigned LVL_W       = 16;
   localparam int unsigned THR_W       = 8;
   localparam int unsigned EDGE_W      = 8;

   typedef logic [1:0] cmd_type;
   localparam cmd_type CMD_LOAD = 2'd0;
   localparam cmd_type CMD_RUN  = 2'd1;
   localparam cmd_type CMD_READ = 2'd2;

   typedef logic [1:0] reg_index_type;
   localparam reg_index_type REG_IMAGE_WIDTH    = 2'd0;
   localparam reg_index_type REG_IMAGE_HEIGHT   = 2'd1;
   localparam reg_index_type REG_LOW_THRESHOLD  = 2'd2;
   localparam reg_index_type REG_HIGH_THRESHOLD = 2'd3;

   typedef logic [1:0] label_type;
   localparam label_type LBL_NONE   = 2'd0;
   localparam label_type LBL_WEAK   = 2'd1;
   localparam label_type LBL_STRONG = 2'd2;

   localparam logic [EDGE_W-1:0] EDGE_ON  = 8'hFF;
   localparam logic [EDGE_W-1:0] EDGE_OFF = 8'h00;

   typedef logic [3:0] nb_type;
   localparam nb_type NB_FIRST  = 4'd0;
   localparam nb_type NB_CENTER = 4'd4;
   localparam nb_type NB_LAST   = 4'd8;

   typedef struct packed {
      logic [PIX_AW-1:0] idx;
      logic [DIM_W-1:0]  y;
      logic [DIM_W-1:0]  x;
   } stk_entry_type;

   typedef struct packed {
      logic load_we;
      logic read_issue;
      logic scan_reset;
      logic label_step;
      logic scan_read;
      logic scan_advance;
      logic push_scan;
      logic pop;
      logic latch_cur;
      logic nb_issue;
      logic nb_advance;
      logic nb_mark;
      logic run_done;
   } ctl_type;

   typedef struct packed {
      logic scan_end;
      logic scan_strong;
      logic stack_empty;
      logic nb_valid;
      logic nb_last;
      logic nb_weak;
   } sts_type;

   function automatic logic [1:0] nb_dy(input nb_type nb);
      logic [1:0] d;
      case (nb)
         4'd0, 4'd1, 4'd2: d = 2'd0;
         4'd3, 4'd4, 4'd5: d = 2'd1;
         default:          d = 2'd2;
      endcase
      return d;
   endfunction

   function automatic logic [1:0] nb_dx(input nb_type nb);
      logic [1:0] d;
      case (nb)
         4'd0, 4'd3, 4'd6: d = 2'd0;
         4'd1, 4'd4, 4'd7: d = 2'd1;
         default:          d = 2'd2;
      endcase
      return d;
   endfunction

endpackage

### rtl/het_ram.sv
// Generic simple dual-port RAM with registered read.
module het_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/het_ctrl.sv
// Controller state machine: command decode, labelling pass, scan and flood fill sequencing.
module het_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  het_pkg::cmd_type command,
   output logic             busy,
   output het_pkg::ctl_type ctl,
   input  het_pkg::sts_type sts
);

   import het_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_LABEL    = 9'b000000010,
      S_SCAN_RD  = 9'b000000100,
      S_SCAN_CHK = 9'b000001000,
      S_POP      = 9'b000010000,
      S_POP_WAIT = 9'b000100000,
      S_NB_RD    = 9'b001000000,
      S_NB_CHK   = 9'b010000000,
      S_DONE     = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      ctl      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (command)
                  CMD_LOAD: ctl.load_we = 1'b1;
                  CMD_READ: ctl.read_issue = 1'b1;
                  CMD_RUN: begin
                     ctl.scan_reset = 1'b1;
                     state_in       = S_LABEL;
                  end
                  default: ;
               endcase
            end
         end
         S_LABEL: begin
            if (sts.scan_end) begin
               ctl.scan_reset = 1'b1;
               state_in       = S_SCAN_RD;
            end else begin
               ctl.label_step = 1'b1;
            end
         end
         S_SCAN_RD: begin
            if (sts.scan_end) begin
               state_in = S_DONE;
            end else begin
               ctl.scan_read = 1'b1;
               state_in      = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            ctl.scan_advance = 1'b1;
            if (sts.scan_strong) begin
               ctl.push_scan = 1'b1;
               state_in      = S_POP;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_POP: begin
            if (sts.stack_empty) begin
               state_in = S_SCAN_RD;
            end else begin
               ctl.pop  = 1'b1;
               state_in = S_POP_WAIT;
            end
         end
         S_POP_WAIT: begin
            ctl.latch_cur = 1'b1;
            state_in      = S_NB_RD;
         end
         S_NB_RD: begin
            if (sts.nb_valid) begin
               ctl.nb_issue = 1'b1;
               state_in     = S_NB_CHK;
            end else if (sts.nb_last) begin
               state_in = S_POP;
            end else begin
               ctl.nb_advance = 1'b1;
            end
         end
         S_NB_CHK: begin
            ctl.nb_mark = sts.nb_weak;
            if (sts.nb_last) begin
               state_in = S_POP;
            end else begin
               ctl.nb_advance = 1'b1;
               state_in       = S_NB_RD;
            end
         end
         S_DONE: begin
            ctl.run_done = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

### rtl/het_dp.sv
// Datapath: configuration registers, pixel, label and stack memories, counters and result beat.
module het_dp #(
   parameter int unsigned MAX_WIDTH  = 256,
   parameter int unsigned MAX_HEIGHT = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  het_pkg::reg_index_type        csr_index,
   input  logic [het_pkg::DIM_W-1:0]     csr_wdata,
   input  logic [het_pkg::PIX_AW-1:0]    req_pixel_index,
   input  logic [het_pkg::LVL_W-1:0]     req_edge_level,
   input  het_pkg::ctl_type              ctl,
   output het_pkg::sts_type              sts,
   output logic                          rsp_strobe,
   output logic [het_pkg::EDGE_W-1:0]    rsp_edge_out,
   output logic                          rsp_run_done
);

   import het_pkg::*;

   localparam int unsigned STK_W = $bits(stk_entry_type);

   logic [DIM_W-1:0]   width_ff;
   logic [DIM_W-1:0]   height_ff;
   logic [THR_W-1:0]   low_ff;
   logic [THR_W-1:0]   high_ff;

   logic [DIM_W-1:0]   w_eff;
   logic [DIM_W-1:0]   h_eff;
   logic [2*DIM_W-1:0] prod;
   logic [CNT_W-1:0]   npix;
   logic [DIM_W-1:0]   w_ff;
   logic [DIM_W-1:0]   h_ff;
   logic [CNT_W-1:0]   npix_ff;

   logic [CNT_W-1:0]   scan_idx_ff;
   logic [DIM_W-1:0]   scan_x_ff;
   logic [DIM_W-1:0]   scan_y_ff;

   logic               wl_valid_ff;
   logic [PIX_AW-1:0]  wl_idx_ff;
   logic [LVL_W-1:0]   level_rd;
   label_type          cls;

   logic               lbl_we;
   logic [PIX_AW-1:0]  lbl_waddr;
   label_type          lbl_wdata;
   logic [PIX_AW-1:0]  lbl_raddr;
   label_type          lbl_rd;

   logic [CNT_W-1:0]   sp_ff;
   logic [CNT_W-1:0]   sp_m1;
   logic               push;
   stk_entry_type      stk_wdata;
   stk_entry_type      stk_rd;

   stk_entry_type      cur_ff;
   nb_type             nb_ff;
   stk_entry_type      cand_ff;
   stk_entry_type      cand_next;
   logic [1:0]         dyc;
   logic [1:0]         dxc;
   logic [DIM_W:0]     ny;
   logic [DIM_W:0]     nx;
   logic [CNT_W:0]     ni_row;
   logic [CNT_W:0]     ni;
   logic               cand_ok;

   logic               rd_pend_ff;
   logic [PIX_AW-1:0]  rd_idx_ff;
   logic               rsp_valid_ff;
   logic [EDGE_W-1:0]  rsp_edge_ff;
   logic               rsp_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'd256;
         height_ff <= 9'd256;
         low_ff    <= 8'd0;
         high_ff   <= 8'd255;
      end else if (csr_we) begin
         case (csr_index)
            REG_IMAGE_WIDTH:    width_ff  <= csr_wdata;
            REG_IMAGE_HEIGHT:   height_ff <= csr_wdata;
            REG_LOW_THRESHOLD:  low_ff    <= csr_wdata[THR_W-1:0];
            REG_HIGH_THRESHOLD: high_ff   <= csr_wdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      w_eff = width_ff;
      if (width_ff == '0) begin
         w_eff = DIM_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = DIM_W'(MAX_WIDTH);
      end
      h_eff = height_ff;
      if (height_ff == '0) begin
         h_eff = DIM_W'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_eff = DIM_W'(MAX_HEIGHT);
      end
      prod = {{DIM_W{1'b0}}, w_eff} * {{DIM_W{1'b0}}, h_eff};
      if (32'(prod) > STORE_DEPTH) begin
         npix = CNT_W'(STORE_DEPTH);
      end else begin
         npix = CNT_W'(prod);
      end
   end

   always_ff @(posedge clock) begin
      w_ff    <= w_eff;
      h_ff    <= h_eff;
      npix_ff <= npix;
   end

   always_ff @(posedge clock) begin
      if (ctl.scan_reset) begin
         scan_idx_ff <= '0;
         scan_x_ff   <= '0;
         scan_y_ff   <= '0;
      end else if (ctl.label_step || ctl.scan_advance) begin
         scan_idx_ff <= scan_idx_ff + CNT_W'(1);
         if ({1'b0, scan_x_ff} + (DIM_W+1)'(1) == {1'b0, w_ff}) begin
            scan_x_ff <= '0;
            scan_y_ff <= scan_y_ff + DIM_W'(1);
         end else begin
            scan_x_ff <= scan_x_ff + DIM_W'(1);
         end
      end
   end

   het_ram #(
      .WIDTH (LVL_W),
      .DEPTH (STORE_DEPTH)
   ) u_level_ram (
      .clock   (clock),
      .wr_en   (ctl.load_we),
      .wr_addr (req_pixel_index),
      .wr_data (req_edge_level),
      .rd_addr (scan_idx_ff[PIX_AW-1:0]),
      .rd_data (level_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wl_valid_ff <= 1'b0;
      end else begin
         wl_valid_ff <= ctl.label_step;
      end
   end

   always_ff @(posedge clock) begin
      wl_idx_ff <= scan_idx_ff[PIX_AW-1:0];
   end

   always_comb begin
      if (level_rd > {high_ff, 8'h00}) begin
         cls = LBL_STRONG;
      end else if (level_rd > {low_ff, 8'h00}) begin
         cls = LBL_WEAK;
      end else begin
         cls = LBL_NONE;
      end
   end

   always_comb begin
      dyc = nb_dy(nb_ff);
      dxc = nb_dx(nb_ff);
      ny  = {1'b0, cur_ff.y} + {{(DIM_W-1){1'b0}}, dyc} - (DIM_W+1)'(1);
      nx  = {1'b0, cur_ff.x} + {{(DIM_W-1){1'b0}}, dxc} - (DIM_W+1)'(1);
      case (dyc)
         2'd0:    ni_row = {2'b00, cur_ff.idx} - (CNT_W+1)'(w_ff);
         2'd2:    ni_row = {2'b00, cur_ff.idx} + (CNT_W+1)'(w_ff);
         default: ni_row = {2'b00, cur_ff.idx};
      endcase
      ni = ni_row + (CNT_W+1)'(dxc) - (CNT_W+1)'(1);
      cand_ok = (nb_ff != NB_CENTER)
         && !(dyc == 2'd0 && cur_ff.y == '0)
         && !(dxc == 2'd0 && cur_ff.x == '0)
         && (ny < {1'b0, h_ff})
         && (nx < {1'b0, w_ff})
         && (ni < {1'b0, npix_ff});
      cand_next.idx = ni[PIX_AW-1:0];
      cand_next.y   = ny[DIM_W-1:0];
      cand_next.x   = nx[DIM_W-1:0];
   end

   always_comb begin
      lbl_we    = wl_valid_ff || ctl.nb_mark;
      lbl_waddr = wl_valid_ff ? wl_idx_ff : cand_ff.idx;
      lbl_wdata = wl_valid_ff ? cls : LBL_STRONG;
      if (ctl.read_issue) begin
         lbl_raddr = req_pixel_index;
      end else if (ctl.scan_read) begin
         lbl_raddr = scan_idx_ff[PIX_AW-1:0];
      end else begin
         lbl_raddr = cand_next.idx;
      end
   end

   het_ram #(
      .WIDTH ($bits(label_type)),
      .DEPTH (STORE_DEPTH)
   ) u_label_ram (
      .clock   (clock),
      .wr_en   (lbl_we),
      .wr_addr (lbl_waddr),
      .wr_data (lbl_wdata),
      .rd_addr (lbl_raddr),
      .rd_data (lbl_rd)
   );

   assign push  = ctl.push_scan || ctl.nb_mark;
   assign sp_m1 = sp_ff - CNT_W'(1);

   always_comb begin
      if (ctl.push_scan) begin
         stk_wdata.idx = scan_idx_ff[PIX_AW-1:0];
         stk_wdata.y   = scan_y_ff;
         stk_wdata.x   = scan_x_ff;
      end else begin
         stk_wdata = cand_ff;
      end
   end

   het_ram #(
      .WIDTH (STK_W),
      .DEPTH (STORE_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (sp_ff[PIX_AW-1:0]),
      .wr_data (stk_wdata),
      .rd_addr (sp_m1[PIX_AW-1:0]),
      .rd_data (stk_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
      end else if (push) begin
         sp_ff <= sp_ff + CNT_W'(1);
      end else if (ctl.pop) begin
         sp_ff <= sp_m1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.latch_cur) begin
         cur_ff <= stk_rd;
         nb_ff  <= NB_FIRST;
      end else if (ctl.nb_advance) begin
         nb_ff <= nb_ff + 4'd1;
      end
      if (ctl.nb_issue) begin
         cand_ff <= cand_next;
      end
   end

   always_comb begin
      sts.scan_end    = (scan_idx_ff == npix_ff);
      sts.scan_strong = (lbl_rd == LBL_STRONG);
      sts.stack_empty = (sp_ff == '0);
      sts.nb_valid    = cand_ok;
      sts.nb_last     = (nb_ff == NB_LAST);
      sts.nb_weak     = (lbl_rd == LBL_WEAK);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_pend_ff   <= ctl.read_issue;
         rsp_valid_ff <= rd_pend_ff || ctl.run_done;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.read_issue) begin
         rd_idx_ff <= req_pixel_index;
      end
      if (rd_pend_ff) begin
         rsp_edge_ff <= (({1'b0, rd_idx_ff} < npix_ff) && (lbl_rd == LBL_STRONG))
                        ? EDGE_ON : EDGE_OFF;
         rsp_done_ff <= 1'b0;
      end else if (ctl.run_done) begin
         rsp_edge_ff <= EDGE_OFF;
         rsp_done_ff <= 1'b1;
      end
   end

   assign rsp_strobe   = rsp_valid_ff;
   assign rsp_edge_out = rsp_edge_ff;
   assign rsp_run_done = rsp_done_ff;

endmodule

### rtl/hysteresis_edge_tracking_core.sv
// Top level of the hysteresis edge tracking core: controller plus datapath.
//
//   channel   ports                                    handshake
//   request   req_command req_pixel_index req_edge_level  start, taken when busy is low
//   result    rsp_edge_out rsp_run_done                 rsp_strobe, one cycle, no stall
//   csr       csr_index csr_wdata                      csr_we, written at once
//
// Load, read: one per cycle while busy is low. Load: no result beat. Read: beat registered
// in label memory, then result register. Run: busy for a labelling pass over the n pixels
// in use, then a scan flooding from each strong pixel to weak neighbors, paced by the single
// read port of the label memory, visited once per scan step and once per neighbor.
// Synchronous reset clears control state, sets csr defaults; memories are not cleared.
// The result side cannot stall; every beat is shown for exactly one cycle.
module hysteresis_edge_tracking_core #(
   parameter int unsigned MAX_WIDTH  = 256,
   parameter int unsigned MAX_HEIGHT = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  het_pkg::cmd_type              req_command,
   input  logic [het_pkg::PIX_AW-1:0]    req_pixel_index,
   input  logic [het_pkg::LVL_W-1:0]     req_edge_level,
   output logic                          rsp_strobe,
   output logic [het_pkg::EDGE_W-1:0]    rsp_edge_out,
   output logic                          rsp_run_done,
   input  logic                          csr_we,
   input  het_pkg::reg_index_type        csr_index,
   input  logic [het_pkg::DIM_W-1:0]     csr_wdata
);

   import het_pkg::*;

   ctl_type ctl;
   sts_type sts;

   het_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .command (req_command),
      .busy    (busy),
      .ctl     (ctl),
      .sts     (sts)
   );

   het_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_pixel_index (req_pixel_index),
      .req_edge_level  (req_edge_level),
      .ctl             (ctl),
      .sts             (sts),
      .rsp_strobe      (rsp_strobe),
      .rsp_edge_out    (rsp_edge_out),
      .rsp_run_done    (rsp_run_done)
   );

endmodule

### rtl/het_checker.sv
// Port-level checker for the hysteresis edge tracking core, with its bind.
module het_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input het_pkg::cmd_type           req_command,
   input logic                       rsp_strobe,
   input logic [het_pkg::EDGE_W-1:0] rsp_edge_out,
   input logic                       rsp_run_done
);

   import het_pkg::*;

   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command == CMD_RUN) |=> busy)
      else $error("run beat did not raise busy");

   a_read_beat: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command == CMD_READ) |-> ##2 (rsp_strobe && !rsp_run_done))
      else $error("read beat missing its result");

   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command == CMD_LOAD) |-> ##2 !rsp_strobe)
      else $error("load beat produced a result");

   a_edge_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_edge_out == EDGE_ON || rsp_edge_out == EDGE_OFF))
      else $error("edge value neither on nor off");

   a_done_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_run_done) |-> ($past(busy) && !busy))
      else $error("run result outside the end of a run");

endmodule

bind hysteresis_edge_tracking_core het_checker u_het_checker (.*);

### sim/hysteresis_edge_tracking_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the hysteresis edge tracking core: loads, runs and reads vs. a predictor.
module hysteresis_edge_tracking_core_tb;
   import het_pkg::*;

   localparam int unsigned MAX_W        = 256;
   localparam int unsigned MAX_H        = 256;
   localparam cmd_type     CMD_UNUSED   = 2'd3;
   localparam int unsigned STALL_LIMIT  = 200000;
   localparam int unsigned ITEM_TARGET  = 1700;
   localparam int unsigned TAIL_ITEMS   = 250;
   localparam int unsigned DRAIN_SETTLE = 8;

   typedef struct packed {
      logic [EDGE_W-1:0] edge_out;
      logic              run_done;
   } edge_beat_type;

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                start           = 1'b0;
   logic                busy;
   cmd_type             req_command     = CMD_LOAD;
   logic [PIX_AW-1:0]   req_pixel_index = '0;
   logic [LVL_W-1:0]    req_edge_level  = '0;
   logic                rsp_strobe;
   logic [EDGE_W-1:0]   rsp_edge_out;
   logic                rsp_run_done;
   logic                csr_we          = 1'b0;
   reg_index_type       csr_index       = REG_IMAGE_WIDTH;
   logic [DIM_W-1:0]    csr_wdata       = '0;

   logic [LVL_W-1:0]    level_mem [STORE_DEPTH];
   label_type           label_mem [STORE_DEPTH];
   bit                  label_valid [STORE_DEPTH];
   logic [DIM_W-1:0]    width_reg  = 9'd256;
   logic [DIM_W-1:0]    height_reg = 9'd256;
   logic [THR_W-1:0]    low_reg    = 8'd0;
   logic [THR_W-1:0]    high_reg   = 8'd255;

   edge_beat_type       expected_edges [$];
   int                  mismatches   = 0;
   int                  items_sent   = 0;
   int                  stall_cycles = 0;
   bit                  idle_on      = 1'b1;

   hysteresis_edge_tracking_core #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_pixel_index (req_pixel_index),
      .req_edge_level  (req_edge_level),
      .rsp_strobe      (rsp_strobe),
      .rsp_edge_out    (rsp_edge_out),
      .rsp_run_done    (rsp_run_done),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int clamp_dim(input logic [DIM_W-1:0] raw, input int unsigned lim);
      if (raw == 0) return 1;
      if (raw > lim) return lim;
      return raw;
   endfunction

   function automatic int pixel_count();
      return clamp_dim(width_reg, MAX_W) * clamp_dim(height_reg, MAX_H);
   endfunction

   function automatic void track_edges();
      int w;
      int h;
      int n;
      int cur;
      int y;
      int x;
      int ny;
      int nx;
      int ni;
      int trail [$];
      w = clamp_dim(width_reg, MAX_W);
      h = clamp_dim(height_reg, MAX_H);
      n = w * h;
      for (int i = 0; i < n; i++) begin
         if (level_mem[i] > {high_reg, 8'h00}) label_mem[i] = LBL_STRONG;
         else if (level_mem[i] > {low_reg, 8'h00}) label_mem[i] = LBL_WEAK;
         else label_mem[i] = LBL_NONE;
         label_valid[i] = 1'b1;
      end
      for (int i = 0; i < n; i++) begin
         if (label_mem[i] != LBL_STRONG) continue;
         trail.push_back(i);
         while (trail.size() > 0) begin
            cur = trail.pop_back();
            y = cur / w;
            x = cur % w;
            for (int dy = -1; dy <= 1; dy++) begin
               for (int dx = -1; dx <= 1; dx++) begin
                  ny = y + dy;
                  nx = x + dx;
                  if (ny < 0 || nx < 0 || ny >= h || nx >= w) continue;
                  ni = ny * w + nx;
                  if (label_mem[ni] == LBL_WEAK) begin
                     label_mem[ni] = LBL_STRONG;
                     trail.push_back(ni);
                  end
               end
            end
         end
      end
   endfunction

   function automatic logic [LVL_W-1:0] gen_level();
      int unsigned lo;
      int unsigned hi;
      int unsigned pick;
      lo   = low_reg * 256;
      hi   = high_reg * 256;
      pick = $urandom_range(0, 19);
      if (pick < 3) return LVL_W'($urandom_range(hi + 1, 65535));
      if (pick < 14 && hi > lo) return LVL_W'($urandom_range(lo + 1, hi));
      if (pick < 18) return LVL_W'($urandom_range(0, lo));
      return LVL_W'($urandom);
   endfunction

   // stay off pixels that no run has labelled yet
   function automatic int unsigned pick_read_index(input int n);
      int unsigned r;
      int unsigned idx;
      r = $urandom_range(0, 9);
      if (r < 7) idx = $urandom_range(0, n - 1);
      else if (r == 7) idx = n;
      else idx = $urandom_range(0, 65535);
      if (idx < n && !label_valid[idx]) idx = n;
      if (idx > 65535) idx = 65535;
      return idx;
   endfunction

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: ERROR: %s", $time, msg);
   endtask

   task automatic send_beat(input cmd_type cmd, input int unsigned idx,
                            input logic [LVL_W-1:0] lvl);
      int n;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_command     <= cmd;
      req_pixel_index <= idx[PIX_AW-1:0];
      req_edge_level  <= lvl;
      start           <= 1'b1;
      do @(posedge clock); while (busy);
      n = pixel_count();
      case (cmd)
         CMD_LOAD: level_mem[idx] = lvl;
         CMD_RUN: begin
            track_edges();
            expected_edges.push_back(edge_beat_type'{EDGE_OFF, 1'b1});
         end
         CMD_READ: expected_edges.push_back(edge_beat_type'{
            (idx < n && label_mem[idx] == LBL_STRONG) ? EDGE_ON : EDGE_OFF, 1'b0});
         default: ;
      endcase
      if (cmd != CMD_UNUSED) items_sent++;
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (expected_edges.size() != 0) @(posedge clock);
      repeat (DRAIN_SETTLE) @(posedge clock);
   endtask

   task automatic write_cfg(input int w, input int h, input int lo, input int hi);
      reg_index_type    order [4];
      logic [DIM_W-1:0] vals [4];
      order = '{REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_LOW_THRESHOLD, REG_HIGH_THRESHOLD};
      vals  = '{DIM_W'(w), DIM_W'(h), DIM_W'(lo), DIM_W'(hi)};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= order[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we     <= 1'b0;
      width_reg  = DIM_W'(w);
      height_reg = DIM_W'(h);
      low_reg    = THR_W'(lo);
      high_reg   = THR_W'(hi);
   endtask

   task automatic noise_beat(input int n);
      case ($urandom_range(0, 2))
         0:       send_beat(CMD_UNUSED, $urandom_range(0, 65535), LVL_W'($urandom));
         1:       send_beat(CMD_LOAD, $urandom_range(0, 65535), LVL_W'($urandom));
         default: send_beat(CMD_READ, pick_read_index(n), LVL_W'($urandom));
      endcase
   endtask

   task automatic image_phase(input int w, input int h, input int lo, input int hi,
                              input bit mid_pause);
      int n;
      int reads;
      wait_idle();
      write_cfg(w, h, lo, hi);
      n = pixel_count();
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0) noise_beat(n);
         send_beat(CMD_LOAD, i, gen_level());
      end
      send_beat(CMD_RUN, $urandom_range(0, 65535), LVL_W'($urandom));
      reads = n / 2 + 6;
      for (int r = 0; r < reads; r++) begin
         if (mid_pause && r == reads / 2) wait_idle();
         if ($urandom_range(0, 9) == 0) noise_beat(n);
         send_beat(CMD_READ, pick_read_index(n), LVL_W'($urandom));
      end
   endtask

   task automatic test_directed_pixels();
      logic [LVL_W-1:0] levels [12];
      levels = '{16'hFFFF, 16'h8000, 16'h0000, 16'h3000,
                 16'h8001, 16'h0000, 16'h0FFF, 16'h1000,
                 16'h0000, 16'h1001, 16'h0000, 16'h2000};
      idle_on = 1'b0;
      write_cfg(4, 3, 16, 128);
      for (int i = 0; i < 12; i++) send_beat(CMD_LOAD, i, levels[i]);
      send_beat(CMD_UNUSED, 16'hFFFF, 16'hFFFF);
      send_beat(CMD_RUN, 16'hFFFF, 16'h0000);
      for (int i = 0; i < 12; i++) send_beat(CMD_READ, i, 16'h0000);
      send_beat(CMD_READ, 12, 16'h0000);
      send_beat(CMD_READ, 16'hFFFF, 16'hFFFF);
   endtask

   task automatic test_size_saturation();
      idle_on = 1'b1;
      image_phase(0, 0, 40, 90, 1'b1);
      image_phase(511, 0, 20, 200, 1'b0);
      image_phase(1, 300, 10, 150, 1'b0);
   endtask

   task automatic test_threshold_extremes();
      image_phase(5, 4, 0, 0, 1'b0);
      image_phase(6, 3, 255, 255, 1'b0);
      image_phase(4, 4, 200, 50, 1'b0);
      image_phase(7, 2, 0, 255, 1'b0);
      image_phase(3, 5, 100, 100, 1'b0);
   endtask

   task automatic test_random_images();
      int w;
      int h;
      int lo;
      int hi;
      while (items_sent < ITEM_TARGET - TAIL_ITEMS) begin
         idle_on = ($urandom_range(0, 3) != 0);
         w  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 16);
         h  = $urandom_range(1, 12);
         lo = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 160);
         hi = ($urandom_range(0, 5) == 0) ? 255 : $urandom_range(lo, 255);
         image_phase(w, h, lo, hi, $urandom_range(0, 3) == 0);
      end
   endtask

   task automatic test_back_to_back();
      idle_on = 1'b0;
      image_phase(12, 9, 30, 120, 1'b0);
   endtask

   always @(posedge clock) begin
      edge_beat_type want;
      if (!reset && rsp_strobe) begin
         if (expected_edges.size() == 0) begin
            note_mismatch($sformatf("beat with nothing pending: edge_out=%0d run_done=%0d",
                                    rsp_edge_out, rsp_run_done));
         end else begin
            want = expected_edges.pop_front();
            if (rsp_edge_out !== want.edge_out)
               note_mismatch($sformatf("edge_out expected %0d got %0d",
                                       want.edge_out, rsp_edge_out));
            if (rsp_run_done !== want.run_done)
               note_mismatch($sformatf("run_done expected %0d got %0d",
                                       want.run_done, rsp_run_done));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("hysteresis_edge_tracking_core: mismatch");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed_pixels();
      test_size_saturation();
      test_threshold_extremes();
      test_random_images();
      test_back_to_back();
      wait_idle();
      if (mismatches == 0 && expected_edges.size() == 0) begin
         $display("hysteresis_edge_tracking_core: match");
      end else begin
         $display("hysteresis_edge_tracking_core: mismatch");
      end
      $finish;
   end

endmodule

### hysteresis_edge_tracking_core.f
rtl/het_pkg.sv
rtl/het_ram.sv
rtl/het_ctrl.sv
rtl/het_dp.sv
rtl/hysteresis_edge_tracking_core.sv
rtl/het_checker.sv
sim/hysteresis_edge_tracking_core_tb.sv
